FILE: sv/dqsdw_pkg.sv
// Package for the DQS delay window trainer.
// Holds the phase and command codes, the lane word constants and the word-building functions.
// No dependencies.
`default_nettype none

package dqsdw_pkg;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam logic [15:0] LANE0_BASE = 16'h7400;
    localparam logic [15:0] LANE1_BASE = 16'h0074;

    localparam logic [4:0] UC_RESET   = 5'd7;
    localparam logic [3:0] UF_RESET   = 4'd0;
    localparam logic [3:0] LC_RESET   = 4'd6;
    localparam logic [3:0] LF_RESET   = 4'd15;
    localparam logic [4:0] UC_OVERRUN = 5'd16;
    localparam logic [4:0] TRIAL_MAX  = 5'd15;
    localparam logic [4:0] UP_START   = 5'd7;
    localparam logic [4:0] DOWN_START = 5'd6;
    localparam logic [4:0] FINE_TOP   = 5'd15;
    localparam logic [3:0] BOUND_REF  = 4'd8;
    localparam logic [4:0] MID_CARRY  = 5'd16;
    localparam logic [4:0] MID_ADJUST = 5'd8;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_MAXC = 6'b000010,
        PH_MAXF = 6'b000100,
        PH_MINC = 6'b001000,
        PH_MINF = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        lane_now;
        logic        done_res;
        logic [15:0] delay_word;
    } result_t;

    function automatic logic [3:0] bound_of(input logic [3:0] reading);
        if (reading <= BOUND_REF)
        begin
            return BOUND_REF - reading;
        end
        return 4'd0;
    endfunction

    function automatic logic [15:0] lane_word(input logic lane, input logic [4:0] coarse,
                                              input logic [4:0] fine);
        logic [23:0] w;
        if (lane)
        begin
            w = 24'(LANE1_BASE) | (24'(coarse) << 12) | (24'(fine) << 8);
        end
        else
        begin
            w = 24'(LANE0_BASE) | (24'(coarse) << 4) | 24'(fine);
        end
        return w[15:0];
    endfunction

    // Midpoint of one lane: coarse in the upper five bits, fine in the lower five.
    function automatic logic [9:0] lane_mid(input logic [4:0] uc, input logic [3:0] lc,
                                            input logic [3:0] uf, input logic [3:0] lf);
        logic [5:0] sc;
        logic [4:0] fsum;
        logic [4:0] tmp;
        logic [4:0] c;
        logic [4:0] f;
        sc   = 6'(uc) + 6'(lc);
        fsum = 5'(uf) + 5'(lf);
        tmp  = {2'b00, sc[0], 2'b00} + {1'b0, fsum[4:1]};
        c    = sc[5:1];
        f    = tmp;
        if (tmp >= MID_CARRY)
        begin
            c = c + 5'd1;
            f = tmp - MID_ADJUST;
        end
        return {c, f};
    endfunction

    function automatic logic [15:0] final_word(input logic [9:0] mid0, input logic [9:0] mid1);
        logic [23:0] w;
        w = (24'(mid1[9:5]) << 12) | (24'(mid1[4:0]) << 8) | (24'(mid0[9:5]) << 4)
            | 24'(mid0[4:0]);
        return w[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/dqs_delay_window_trainer_top.sv
// DQS delay window trainer: search sequencer for two byte lanes and a two-entry output buffer.
// Depends on dqsdw_pkg.
// Each accepted item's result is registered in the output buffer and offered on the master side.
// Throughput: one item per cycle; the two-entry output buffer keeps input open while one result
// waits, and input stalls only when both entries are full.
// Reset: rst_n clears the search state to its idle values and empties the output buffer.
`default_nettype none

module dqs_delay_window_trainer_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // dll_coarse[3:0], dll_fine[7:4], passed[8], zeros
    input  wire logic        s_tuser,   // command[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // delay_word[15:0]
    output logic [1:0]       m_tuser    // done_res[0], lane_now[1]
);
    import dqsdw_pkg::*;

    logic [4:0] uc_reg [2];
    logic [4:0] uc_next [2];
    logic [3:0] uf_reg [2];
    logic [3:0] uf_next [2];
    logic [3:0] lc_reg [2];
    logic [3:0] lc_next [2];
    logic [3:0] lf_reg [2];
    logic [3:0] lf_next [2];
    logic [4:0] trial_reg;
    logic [4:0] trial_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       lane_reg;
    logic       lane_next;
    logic [3:0] cbound_reg;
    logic [3:0] cbound_next;
    logic [3:0] fbound_reg;
    logic [3:0] fbound_next;

    result_t    head_reg;
    result_t    head_next;
    result_t    tail_reg;
    result_t    tail_next;
    logic       head_valid_reg;
    logic       head_valid_next;
    logic       tail_valid_reg;
    logic       tail_valid_next;
    result_t    result;

    logic       accept;
    logic       pop;
    logic       ok;
    logic [4:0] t_dec;

    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;
    assign ok     = s_tdata[8];
    assign t_dec  = trial_reg - 5'd1;

    always_comb
    begin
        uc_next     = uc_reg;
        uf_next     = uf_reg;
        lc_next     = lc_reg;
        lf_next     = lf_reg;
        trial_next  = trial_reg;
        phase_next  = phase_reg;
        lane_next   = lane_reg;
        cbound_next = cbound_reg;
        fbound_next = fbound_reg;
        if (accept)
        begin
            if (s_tuser == CMD_START)
            begin
                uc_next     = '{UC_RESET, UC_RESET};
                uf_next     = '{UF_RESET, UF_RESET};
                lc_next     = '{LC_RESET, LC_RESET};
                lf_next     = '{LF_RESET, LF_RESET};
                cbound_next = bound_of(s_tdata[3:0]);
                fbound_next = bound_of(s_tdata[7:4]);
                lane_next   = 1'b0;
                phase_next  = PH_MAXC;
                trial_next  = UP_START;
            end
            else
            begin
                case (phase_reg)
                    PH_MAXC:
                    begin
                        if (!ok || trial_reg >= TRIAL_MAX)
                        begin
                            uc_next[lane_reg] = ok ? UC_OVERRUN : trial_reg;
                            phase_next        = PH_MAXF;
                            trial_next        = 5'd0;
                        end
                        else
                        begin
                            trial_next = trial_reg + 5'd1;
                        end
                    end
                    PH_MAXF:
                    begin
                        if (ok && trial_reg < TRIAL_MAX)
                        begin
                            trial_next = trial_reg + 5'd1;
                        end
                        else
                        begin
                            if (!ok && trial_reg == 5'd0)
                            begin
                                uc_next[lane_reg] = uc_reg[lane_reg] - 5'd1;
                                uf_next[lane_reg] = 4'd15;
                            end
                            else if (!ok)
                            begin
                                uf_next[lane_reg] = t_dec[3:0];
                            end
                            else
                            begin
                                uf_next[lane_reg] = 4'd15;
                            end
                            phase_next = PH_MINC;
                            trial_next = DOWN_START;
                        end
                    end
                    PH_MINC:
                    begin
                        if (!ok || trial_reg == 5'(cbound_reg) || trial_reg == 5'd0)
                        begin
                            lc_next[lane_reg] = trial_reg[3:0];
                            phase_next        = PH_MINF;
                            trial_next        = FINE_TOP;
                        end
                        else if (t_dec >= 5'(cbound_reg))
                        begin
                            trial_next = t_dec;
                        end
                        else
                        begin
                            lc_next[lane_reg] = t_dec[3:0];
                            phase_next        = PH_MINF;
                            trial_next        = FINE_TOP;
                        end
                    end
                    PH_MINF:
                    begin
                        if (ok && trial_reg != 5'(fbound_reg) && trial_reg != 5'd0
                            && t_dec >= 5'(fbound_reg))
                        begin
                            trial_next = t_dec;
                        end
                        else
                        begin
                            if (!ok && trial_reg == FINE_TOP)
                            begin
                                lc_next[lane_reg] = lc_reg[lane_reg] + 4'd1;
                                lf_next[lane_reg] = 4'd0;
                            end
                            else if (!ok)
                            begin
                                lf_next[lane_reg] = trial_reg[3:0] + 4'd1;
                            end
                            else if (trial_reg == 5'(fbound_reg) || trial_reg == 5'd0)
                            begin
                                lf_next[lane_reg] = trial_reg[3:0];
                            end
                            else
                            begin
                                lf_next[lane_reg] = t_dec[3:0];
                            end
                            if (!lane_reg)
                            begin
                                lane_next  = 1'b1;
                                phase_next = PH_MAXC;
                                trial_next = UP_START;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result = '0;
        case (phase_next)
            PH_DONE:
            begin
                result.delay_word = final_word(lane_mid(uc_next[0], lc_next[0], uf_next[0],
                                                        lf_next[0]),
                                               lane_mid(uc_next[1], lc_next[1], uf_next[1],
                                                        lf_next[1]));
                result.done_res   = 1'b1;
            end
            PH_MAXC:
            begin
                result.delay_word = lane_word(lane_next, trial_next, 5'd15);
                result.lane_now   = lane_next;
            end
            PH_MAXF:
            begin
                result.delay_word = lane_word(lane_next, uc_next[lane_next], trial_next);
                result.lane_now   = lane_next;
            end
            PH_MINC:
            begin
                result.delay_word = lane_word(lane_next, trial_next, 5'd0);
                result.lane_now   = lane_next;
            end
            PH_MINF:
            begin
                result.delay_word = lane_word(lane_next, 5'(lc_next[lane_next]), trial_next);
                result.lane_now   = lane_next;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_next       = tail_reg;
                tail_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            if (!head_valid_next)
            begin
                head_next       = result;
                head_valid_next = 1'b1;
            end
            else
            begin
                tail_next       = result;
                tail_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uc_reg         <= '{UC_RESET, UC_RESET};
            uf_reg         <= '{UF_RESET, UF_RESET};
            lc_reg         <= '{LC_RESET, LC_RESET};
            lf_reg         <= '{LF_RESET, LF_RESET};
            trial_reg      <= 5'd0;
            phase_reg      <= PH_IDLE;
            lane_reg       <= 1'b0;
            cbound_reg     <= 4'd0;
            fbound_reg     <= 4'd0;
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            uc_reg         <= uc_next;
            uf_reg         <= uf_next;
            lc_reg         <= lc_next;
            lf_reg         <= lf_next;
            trial_reg      <= trial_next;
            phase_reg      <= phase_next;
            lane_reg       <= lane_next;
            cbound_reg     <= cbound_next;
            fbound_reg     <= fbound_next;
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign s_tready = !tail_valid_reg;
    assign m_tvalid = head_valid_reg;
    assign m_tdata  = head_reg.delay_word;
    assign m_tuser  = {head_reg.lane_now, head_reg.done_res};

    a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg |-> head_valid_reg)
        else $error("Output buffer holds a second entry without a first.");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("Accepted item produced no result.");

    a_done_on_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && head_reg.done_res) |-> !head_reg.lane_now)
        else $error("Final word reported with a nonzero lane.");

    a_lane_one_active: assert property (@(posedge clk) disable iff (!rst_n)
        lane_reg |-> (phase_reg != PH_IDLE))
        else $error("Second lane selected while idle.");

endmodule

`default_nettype wire
